// File: rtl/alro_pkg.sv
// Shared types and constants for the audio loop record/overdub block.
// No dependencies; used by alro_ctrl, alro_mem and audio_loop_record_overdub.
`default_nettype none

package alro_pkg;

    localparam int LOOP_DEPTH = 262144;
    localparam int ADDR_W     = $clog2(LOOP_DEPTH);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 16;

    localparam logic [LEN_W-1:0] LOOP_DEPTH_LEN = LEN_W'(LOOP_DEPTH);

    typedef enum logic [1:0] {
        MODE_PAUSED    = 2'd0,
        MODE_PLAYING   = 2'd1,
        MODE_RECORDING = 2'd2,
        MODE_OVERDUB   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REQ_AUDIO   = 2'd0,
        REQ_RECORD  = 2'd1,
        REQ_OVERDUB = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    typedef struct packed {
        logic                       rd;
        logic                       rec;
        logic                       dub;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
    } mem_op_t;

    typedef struct packed {
        mode_t             mode;
        mode_t             pending;
        logic [ADDR_W-1:0] position;
        logic [LEN_W-1:0]  length;
        logic              claim;
        logic              full;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/alro_ctrl.sv
// Loop control state: modes, master flag, length and play position.
// Issues at most one memory operation per audio transfer. Depends on alro_pkg.
`default_nettype none

module alro_ctrl
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               take,
    input  wire alro_pkg::req_t                     req,
    input  wire logic signed [alro_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                               block_start,
    input  wire logic                               control_on,
    input  wire logic                               master_exists,
    input  wire logic                               master_at_start,
    output alro_pkg::mem_op_t                       op,
    output alro_pkg::status_t                       stat
);

    alro_pkg::mode_t                     mode_reg, mode_next;
    alro_pkg::mode_t                     pend_reg, pend_next;
    logic                                master_reg, master_next;
    logic [alro_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [alro_pkg::ADDR_W-1:0]         pos_reg, pos_next;
    logic [alro_pkg::ADDR_W-1:0]         rpos;
    logic [alro_pkg::LEN_W-1:0]          inc;
    logic                                claim;
    logic                                full;

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        master_next = master_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        claim       = 1'b0;
        full        = 1'b0;
        rpos        = '0;
        inc         = '0;
        op          = '0;
        op.sample   = sample;
        unique case (req)
            alro_pkg::REQ_RECORD:
            begin
                if (control_on && pend_reg != alro_pkg::MODE_RECORDING)
                begin
                    len_next = '0;
                    pos_next = '0;
                end
                pend_next = control_on ? alro_pkg::MODE_RECORDING : alro_pkg::MODE_PLAYING;
            end
            alro_pkg::REQ_OVERDUB:
            begin
                pend_next = control_on ? alro_pkg::MODE_OVERDUB : alro_pkg::MODE_PLAYING;
            end
            alro_pkg::REQ_AUDIO:
            begin
                if (!master_exists)
                begin
                    master_next = 1'b0;
                end
                if (block_start && mode_reg != pend_reg)
                begin
                    if (!master_exists)
                    begin
                        mode_next = pend_reg;
                        if (pend_reg != alro_pkg::MODE_RECORDING)
                        begin
                            master_next = 1'b1;
                            claim       = 1'b1;
                        end
                    end
                    else if (master_reg || master_at_start)
                    begin
                        mode_next = pend_reg;
                    end
                end
                if (mode_next == alro_pkg::MODE_RECORDING)
                begin
                    if (len_reg < alro_pkg::LOOP_DEPTH_LEN)
                    begin
                        op.rec   = 1'b1;
                        op.addr  = len_reg[alro_pkg::ADDR_W-1:0];
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        full = 1'b1;
                    end
                end
                else if (len_reg != '0)
                begin
                    rpos     = ({1'b0, pos_reg} >= len_reg) ? '0 : pos_reg;
                    op.rd    = 1'b1;
                    op.dub   = (mode_next == alro_pkg::MODE_OVERDUB);
                    op.addr  = rpos;
                    inc      = {1'b0, rpos} + 1'b1;
                    pos_next = (inc >= len_reg) ? '0 : inc[alro_pkg::ADDR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.mode     = mode_next;
        stat.pending  = pend_next;
        stat.position = pos_next;
        stat.length   = len_next;
        stat.claim    = claim;
        stat.full     = full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= alro_pkg::MODE_PAUSED;
            pend_reg   <= alro_pkg::MODE_PAUSED;
            master_reg <= 1'b0;
            len_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            master_reg <= master_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/alro_mem.sv
// Loop sample memory with registered read, delayed write-back and forwarding.
// Record writes and overdub sums are both written one stage late. Depends on alro_pkg.
`default_nettype none

module alro_mem
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                take,
    input  wire alro_pkg::mem_op_t                   op,
    output logic signed [alro_pkg::SAMPLE_W-1:0]     out_sample
);

    localparam int SW = alro_pkg::SAMPLE_W;

    logic [SW-1:0]              ram [alro_pkg::LOOP_DEPTH];
    alro_pkg::mem_op_t          op_reg;
    logic                       op_vld_reg;
    logic [SW-1:0]              q_reg;
    logic                       fwd_reg;
    logic [SW-1:0]              fwd_data_reg;
    logic signed [SW-1:0]       stored;
    logic signed [SW:0]         sum;
    logic signed [SW-1:0]       sum_sat;
    logic                       wr_en;
    logic [SW-1:0]              wr_data;

    assign stored = fwd_reg ? fwd_data_reg : q_reg;
    assign sum    = {stored[SW-1], stored} + {op_reg.sample[SW-1], op_reg.sample};

    always_comb
    begin
        if (sum[SW] != sum[SW-1])
        begin
            sum_sat = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[SW-1:0];
        end
    end

    assign wr_en      = en && op_vld_reg && (op_reg.rec || op_reg.dub);
    assign wr_data    = op_reg.rec ? op_reg.sample : sum_sat;
    assign out_sample = (op_vld_reg && op_reg.rd) ? stored : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[op_reg.addr] <= wr_data;
        end
        if (en && take && op.rd)
        begin
            q_reg <= ram[op.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg       <= op;
            fwd_reg      <= wr_en && (op.addr == op_reg.addr);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            op_vld_reg <= take;
        end
    end

endmodule

`default_nettype wire

// File: rtl/audio_loop_record_overdub.sv
// Top level of the single-channel audio looper (record, play, overdub).
// Instantiates alro_ctrl and alro_mem; depends on alro_pkg.
//
// Channel  Dir  tdata                                   tuser
// s_axis   in   in_sample, control_on                   req_type, block_start,
//                                                       master_exists, master_at_start
// m_axis   out  out_sample, mode, pending_mode,         claim_master, buffer_full
//               position, loop_length
//
// One transfer per cycle each way unless the output stalls; stage 1 feeds the output register.
// The memory read is registered; overdub sums are written back from the registered
// operation and are forwarded to a following read of the same entry.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears modes, length, position and master flag; memory contents are not cleared.
`default_nettype none

module audio_loop_record_overdub
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [15:0] in_sample, [16] control_on
    input  wire logic [4:0]  s_axis_tuser,  // [1:0] req_type, [2] block_start,
                                            // [3] master_exists, [4] master_at_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [15:0] out_sample, [17:16] mode,
                                            // [19:18] pending_mode, [37:20] position,
                                            // [56:38] loop_length
    output logic [1:0]       m_axis_tuser   // [0] claim_master, [1] buffer_full
);

    logic                                   en;
    logic                                   take;
    alro_pkg::mem_op_t                      op;
    alro_pkg::status_t                      stat;
    alro_pkg::status_t                      s1_stat_reg;
    logic                                   s1_vld_reg;
    logic signed [alro_pkg::SAMPLE_W-1:0]   s1_sample;
    logic                                   m_valid_reg;
    logic [63:0]                            m_data_reg;
    logic [1:0]                             m_user_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign take          = s_axis_tvalid && en;

    alro_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .req             (alro_pkg::req_t'(s_axis_tuser[1:0])),
        .sample          (s_axis_tdata[15:0]),
        .block_start     (s_axis_tuser[2]),
        .control_on      (s_axis_tdata[16]),
        .master_exists   (s_axis_tuser[3]),
        .master_at_start (s_axis_tuser[4]),
        .op              (op),
        .stat            (stat)
    );

    alro_mem u_mem
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (take),
        .op         (op),
        .out_sample (s1_sample)
    );

    always_ff @(posedge clk)
    begin
        if (en && take)
        begin
            s1_stat_reg <= stat;
        end
        if (en && s1_vld_reg)
        begin
            m_data_reg <= {7'd0, s1_stat_reg.length, s1_stat_reg.position,
                           s1_stat_reg.pending, s1_stat_reg.mode, s1_sample};
            m_user_reg <= {s1_stat_reg.full, s1_stat_reg.claim};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= take;
            m_valid_reg <= s1_vld_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_claim_not_rec: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[17:16] != alro_pkg::MODE_RECORDING)
        else $error("master claimed while recording");

    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[17:16] == alro_pkg::MODE_RECORDING &&
            m_axis_tdata[56:38] == alro_pkg::LOOP_DEPTH_LEN)
        else $error("buffer full reported below capacity");

    a_rec_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == alro_pkg::MODE_RECORDING |->
            m_axis_tdata[15:0] == 16'd0)
        else $error("audio output while recording");

    a_pipe_fill: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_vld_reg)
        else $error("accepted transfer lost in pipeline");
`endif

endmodule

`default_nettype wire

// File: tb/audio_loop_record_overdub_tb.sv
// Self-checking testbench for audio_loop_record_overdub: directed table, a short
// record/play/overdub pass and randomized record/play/overdub episodes under random backpressure.
// Depends on alro_pkg and the audio_loop_record_overdub RTL.
module audio_loop_record_overdub_tb;
    import alro_pkg::*;

    typedef struct packed {
        req_t               req;
        logic signed [15:0] smp;
        logic               start;
        logic               on;
        logic               mex;
        logic               mzero;
    } loop_in_t;

    typedef struct packed {
        logic [15:0]       smp;
        mode_t             mode;
        mode_t             pending;
        logic [ADDR_W-1:0] position;
        logic [LEN_W-1:0]  length;
        logic              claim;
        logic              full;
    } loop_out_t;

    typedef struct {
        loop_in_t  it;
        bit        typed;
        loop_out_t want;
    } dir_row_t;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1350;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [4:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // looper state as the block should hold it
    logic signed [15:0] tape [LOOP_DEPTH];
    logic [LEN_W-1:0]   tape_len;
    logic [ADDR_W-1:0]  play_idx;
    mode_t              cur_mode;
    mode_t              want_mode;
    logic               own_master;

    loop_out_t outputs_due[$];
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        hold_asks;
    int        holds_served;
    int        hold_left;
    int        mismatches;
    int        stray_outputs;
    int        results_seen;
    int        items_sent;
    dir_row_t  dir_tab [N_DIRECTED];

    audio_loop_record_overdub i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30000000;
        $display("FAIL audio_loop_record_overdub");
        $finish;
    end

    function automatic loop_out_t advance_looper(loop_in_t it);
        loop_out_t          r;
        logic [LEN_W-1:0]   idx;
        logic signed [15:0] stored;
        logic signed [16:0] sum;
        r = '0;
        case (it.req)
            REQ_RECORD:
            begin
                if (it.on && want_mode != MODE_RECORDING)
                begin
                    tape_len = '0;
                    play_idx = '0;
                end
                if (it.on)
                    want_mode = MODE_RECORDING;
                else
                    want_mode = MODE_PLAYING;
            end
            REQ_OVERDUB:
            begin
                if (it.on)
                    want_mode = MODE_OVERDUB;
                else
                    want_mode = MODE_PLAYING;
            end
            REQ_AUDIO:
            begin
                if (!it.mex)
                    own_master = 1'b0;
                if (it.start && cur_mode != want_mode)
                begin
                    if (!it.mex)
                    begin
                        cur_mode = want_mode;
                        if (cur_mode != MODE_RECORDING)
                        begin
                            own_master = 1'b1;
                            r.claim = 1'b1;
                        end
                    end
                    else if (own_master || it.mzero)
                        cur_mode = want_mode;
                end
                if (cur_mode == MODE_RECORDING)
                begin
                    if (tape_len < LOOP_DEPTH)
                    begin
                        tape[tape_len[ADDR_W-1:0]] = it.smp;
                        tape_len = tape_len + 1'b1;
                    end
                    else
                        r.full = 1'b1;
                end
                else if (tape_len != 0)
                begin
                    idx = LEN_W'(play_idx);
                    if (idx >= tape_len)
                        idx = '0;
                    stored = tape[idx[ADDR_W-1:0]];
                    r.smp = stored;
                    if (cur_mode == MODE_OVERDUB)
                    begin
                        sum = stored + it.smp;
                        if (sum > 17'sd32767)
                            sum = 17'sd32767;
                        else if (sum < -17'sd32768)
                            sum = -17'sd32768;
                        tape[idx[ADDR_W-1:0]] = sum[15:0];
                    end
                    idx = idx + 1'b1;
                    if (idx >= tape_len)
                        idx = '0;
                    play_idx = idx[ADDR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        r.mode     = cur_mode;
        r.pending  = want_mode;
        r.position = play_idx;
        r.length   = tape_len;
        return r;
    endfunction

    function automatic loop_in_t mk(req_t req, logic [15:0] smp, bit start, bit on,
                                    bit mex, bit mzero);
        loop_in_t it;
        it.req   = req;
        it.smp   = smp;
        it.start = start;
        it.on    = on;
        it.mex   = mex;
        it.mzero = mzero;
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic loop_in_t rand_audio(int start_pct, int mex_pct);
        return mk(REQ_AUDIO, rand_sample(), $urandom_range(0, 99) < start_pct,
                  $urandom_range(0, 1), $urandom_range(0, 99) < mex_pct,
                  $urandom_range(0, 1));
    endfunction

    task automatic send_item(input loop_in_t it, input bit typed, input loop_out_t want);
        loop_out_t r;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.on, it.smp};
        s_axis_tuser  <= {it.mzero, it.mex, it.start, it.req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = advance_looper(it);
        outputs_due.insert(outputs_due.size(), typed ? want : r);
        if (it.req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic send(input loop_in_t it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic random_episode();
        int n;
        n = $urandom_range(1, 48);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:
            begin
                send(mk(REQ_RECORD, rand_sample(), 0, 1, 0, 0));
                if ($urandom_range(0, 3) == 0)
                    send(mk(REQ_RECORD, rand_sample(), 0, 1, 1, 1));
                send(rand_audio(100, 30));
                repeat (n)
                    send(rand_audio(5, 60));
                send(mk(REQ_RECORD, rand_sample(), $urandom_range(0, 1), 0, 1, 0));
            end
            7, 8, 9, 10, 11, 12:
            begin
                send(rand_audio(100, 50));
                repeat (n)
                    send(rand_audio(15, 60));
            end
            13, 14, 15, 16:
            begin
                send(mk(REQ_OVERDUB, rand_sample(), 0, 1, 0, 0));
                send(rand_audio(100, 50));
                repeat (n)
                    send(rand_audio(10, 60));
                send(mk(REQ_OVERDUB, rand_sample(), 0, 0, 0, 0));
            end
            default:
            begin
                repeat ($urandom_range(1, 8))
                    send(mk(req_t'($urandom_range(0, 3)), rand_sample(), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    // output side: checks every transfer, then picks tready for the next edge
    initial
    begin
        loop_out_t want;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        holds_served  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (outputs_due.size() == 0)
                begin
                    stray_outputs++;
                    if (stray_outputs <= 10)
                        $display("unexpected result: tdata %0h tuser %0h",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = outputs_due.pop_front();
                    check_field("out_sample", want.smp, m_axis_tdata[15:0]);
                    check_field("mode", want.mode, m_axis_tdata[17:16]);
                    check_field("pending_mode", want.pending, m_axis_tdata[19:18]);
                    check_field("position", want.position, m_axis_tdata[37:20]);
                    check_field("loop_length", want.length, m_axis_tdata[56:38]);
                    check_field("claim_master", want.claim, m_axis_tuser[0]);
                    check_field("buffer_full", want.full, m_axis_tuser[1]);
                end
                results_seen++;
            end
            if (hold_asks != holds_served)
            begin
                holds_served = hold_asks;
                hold_left    = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int guard;
        int phase_goal;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_asks     = 0;
        mismatches    = 0;
        stray_outputs = 0;
        results_seen  = 0;
        items_sent    = 0;
        tape_len      = '0;
        play_idx      = '0;
        cur_mode      = MODE_PAUSED;
        want_mode     = MODE_PAUSED;
        own_master    = 1'b0;

        dir_tab[0]  = '{mk(REQ_UNUSED, 16'h7fff, 1, 1, 1, 1), 1'b1,
                        '{16'h0, MODE_PAUSED, MODE_PAUSED, '0, '0, 1'b0, 1'b0}};
        dir_tab[1]  = '{mk(REQ_AUDIO, 16'h8000, 1, 0, 1, 0), 1'b1,
                        '{16'h0, MODE_PAUSED, MODE_PAUSED, '0, '0, 1'b0, 1'b0}};
        dir_tab[2]  = '{mk(REQ_RECORD, 16'h0000, 0, 1, 0, 0), 1'b1,
                        '{16'h0, MODE_PAUSED, MODE_RECORDING, '0, '0, 1'b0, 1'b0}};
        dir_tab[3]  = '{mk(REQ_RECORD, 16'hffff, 0, 1, 1, 1), 1'b0, '0};
        dir_tab[4]  = '{mk(REQ_AUDIO, 16'h7fff, 1, 0, 0, 0), 1'b1,
                        '{16'h0, MODE_RECORDING, MODE_RECORDING, '0, 19'd1, 1'b0, 1'b0}};
        dir_tab[5]  = '{mk(REQ_AUDIO, 16'h8000, 0, 1, 1, 1), 1'b0, '0};
        dir_tab[6]  = '{mk(REQ_AUDIO, 16'h0001, 0, 0, 1, 0), 1'b0, '0};
        dir_tab[7]  = '{mk(REQ_AUDIO, 16'hffff, 0, 0, 0, 1), 1'b0, '0};
        dir_tab[8]  = '{mk(REQ_OVERDUB, 16'h1234, 0, 1, 0, 0), 1'b0, '0};
        dir_tab[9]  = '{mk(REQ_AUDIO, 16'h4000, 1, 0, 1, 0), 1'b0, '0};
        dir_tab[10] = '{mk(REQ_AUDIO, 16'h7fff, 1, 0, 1, 1), 1'b0, '0};
        dir_tab[11] = '{mk(REQ_AUDIO, 16'h8000, 0, 0, 1, 0), 1'b0, '0};
        dir_tab[12] = '{mk(REQ_OVERDUB, 16'h0000, 0, 0, 1, 1), 1'b0, '0};
        dir_tab[13] = '{mk(REQ_AUDIO, 16'h0003, 1, 0, 0, 0), 1'b0, '0};
        dir_tab[14] = '{mk(REQ_AUDIO, 16'haaaa, 0, 1, 1, 0), 1'b0, '0};
        dir_tab[15] = '{mk(REQ_RECORD, 16'h0000, 0, 0, 0, 0), 1'b0, '0};
        dir_tab[16] = '{mk(REQ_OVERDUB, 16'h0000, 0, 1, 1, 0), 1'b0, '0};
        dir_tab[17] = '{mk(REQ_AUDIO, 16'h5555, 1, 0, 1, 0), 1'b0, '0};
        dir_tab[18] = '{mk(REQ_AUDIO, 16'h8001, 0, 0, 0, 0), 1'b0, '0};
        dir_tab[19] = '{mk(REQ_UNUSED, 16'h0f0f, 0, 1, 0, 1), 1'b0, '0};
        dir_tab[20] = '{mk(REQ_RECORD, 16'h0000, 0, 1, 1, 0), 1'b0, '0};
        dir_tab[21] = '{mk(REQ_AUDIO, 16'h0000, 1, 0, 0, 0), 1'b0, '0};
        dir_tab[22] = '{mk(REQ_RECORD, 16'h0000, 0, 0, 0, 0), 1'b0, '0};
        dir_tab[23] = '{mk(REQ_AUDIO, 16'h7ffe, 1, 1, 1, 1), 1'b0, '0};
        dir_tab[24] = '{mk(REQ_AUDIO, 16'h8000, 0, 0, 1, 1), 1'b0, '0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

        // record a short loop, play it back, then overdub on top of it
        send(mk(REQ_RECORD, 16'h0000, 0, 1, 0, 0));
        send(mk(REQ_AUDIO, rand_sample(), 1, 0, 0, 0));
        repeat (40)
            send(rand_audio(0, 50));
        send(mk(REQ_RECORD, 16'h0000, 0, 0, 0, 0));
        send(mk(REQ_AUDIO, rand_sample(), 1, 0, 0, 0));
        repeat (20)
            send(rand_audio(0, 100));
        send(mk(REQ_OVERDUB, 16'h0000, 0, 1, 0, 0));
        send(mk(REQ_AUDIO, rand_sample(), 1, 0, 1, 0));
        repeat (8)
            send(rand_audio(0, 100));
        send(mk(REQ_OVERDUB, 16'h0000, 0, 0, 0, 0));

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 47 : 0;
            rx_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 29 : 0;
            phase_goal  = items_sent + N_RANDOM / 3;
            if (ph == 2)
                hold_asks++;
            while (items_sent < phase_goal)
                random_episode();
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (outputs_due.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);

        if (mismatches == 0 && stray_outputs == 0 && outputs_due.size() == 0)
            $display("PASS audio_loop_record_overdub");
        else
            $display("FAIL audio_loop_record_overdub");
        $finish;
    end
endmodule
